// ===== hw/rtl/latc_pkg.sv =====
package latc_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int OP_W       = 2;
  localparam int PHASE_W    = 2;
  localparam int CNT_W      = 10;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int DEFAULT_BUFFER_DEPTH = 1024;

  // operation codes carried in the input tuser
  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_READ = 2'd1;
  localparam logic [OP_W-1:0] OP_ARM  = 2'd2;
  localparam logic [OP_W-1:0] OP_STOP = 2'd3;

  // capture phases
  localparam logic [PHASE_W-1:0] PH_IDLE     = 2'd0;
  localparam logic [PHASE_W-1:0] PH_ARMED    = 2'd1;
  localparam logic [PHASE_W-1:0] PH_COUNTING = 2'd2;
  localparam logic [PHASE_W-1:0] PH_READOUT  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_PIN_MASK   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_EDGE_LEVEL = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_POST_COUNT = 2'd2;

  localparam logic [SAMPLE_W-1:0] RST_PIN_MASK   = 16'd1;
  localparam logic [SAMPLE_W-1:0] RST_EDGE_LEVEL = 16'd1;
  localparam logic [CNT_W-1:0]    RST_POST_COUNT = 10'd300;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               rd_valid;
    logic               rd_hit;
    logic               last;
    logic               fired;
  } step_t;

endpackage

// ===== hw/rtl/latc_ram.sv =====
module latc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/latc_core.sv =====
module latc_core #(
  parameter int BUFFER_DEPTH = latc_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [latc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [latc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_accept,
  input  logic [latc_pkg::OP_W-1:0]           op,
  input  logic [latc_pkg::SAMPLE_W-1:0]       sample,
  output logic                                ram_we,
  output logic [$clog2(BUFFER_DEPTH)-1:0]     ram_waddr,
  output logic [latc_pkg::SAMPLE_W-1:0]       ram_wdata,
  output logic                                ram_re,
  output logic [$clog2(BUFFER_DEPTH)-1:0]     ram_raddr,
  output latc_pkg::step_t                     step
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam logic [AW:0]   DEPTH_W = (AW+1)'(BUFFER_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(BUFFER_DEPTH - 1);

  logic [latc_pkg::SAMPLE_W-1:0] pin_mask_r;
  logic [latc_pkg::SAMPLE_W-1:0] edge_level_r;
  logic [latc_pkg::CNT_W-1:0]    post_count_r;

  logic [latc_pkg::PHASE_W-1:0]  phase_r, phase_nxt;
  logic [AW-1:0]                 widx_r, widx_nxt;
  logic [latc_pkg::SAMPLE_W-1:0] prev_r, prev_nxt;
  logic [latc_pkg::CNT_W-1:0]    atc_r, atc_nxt;
  logic [AW-1:0]                 rc_r, rc_nxt;
  // entries below the fill count have been written since reset
  logic [AW:0]                   fill_r, fill_nxt;

  logic                          trig_hit;
  logic [latc_pkg::CNT_W-1:0]    limit;
  logic [latc_pkg::CNT_W-1:0]    atc_inc;
  logic [AW:0]                   rd_sum;
  logic [AW-1:0]                 rd_addr;
  logic [AW-1:0]                 widx_inc;
  logic                          rd_valid;
  logic                          rd_last;
  logic                          fired;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_mask_r   <= latc_pkg::RST_PIN_MASK;
      edge_level_r <= latc_pkg::RST_EDGE_LEVEL;
      post_count_r <= latc_pkg::RST_POST_COUNT;
    end else if (cfg_we) begin
      case (cfg_addr)
        latc_pkg::CFG_PIN_MASK:   pin_mask_r   <= cfg_wdata;
        latc_pkg::CFG_EDGE_LEVEL: edge_level_r <= cfg_wdata;
        latc_pkg::CFG_POST_COUNT: post_count_r <= cfg_wdata[latc_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // edge: masked pin changed and its previous level matches the wanted one
  assign trig_hit = |((sample ^ prev_r) & pin_mask_r & ~(prev_r ^ edge_level_r));
  assign limit    = (post_count_r == '0) ? latc_pkg::CNT_W'(1) : post_count_r;
  assign atc_inc  = atc_r + latc_pkg::CNT_W'(1);
  assign widx_inc = (widx_r == LAST_IDX) ? '0 : widx_r + AW'(1);

  // oldest entry is the next one to be written
  assign rd_sum  = {1'b0, widx_r} + {1'b0, rc_r};
  assign rd_addr = (rd_sum >= DEPTH_W) ? AW'(rd_sum - DEPTH_W) : rd_sum[AW-1:0];

  always_comb begin
    phase_nxt = phase_r;
    widx_nxt  = widx_r;
    prev_nxt  = prev_r;
    atc_nxt   = atc_r;
    rc_nxt    = rc_r;
    fill_nxt  = fill_r;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    rd_valid  = 1'b0;
    rd_last   = 1'b0;
    fired     = 1'b0;
    if (in_accept) begin
      case (op)
        latc_pkg::OP_TICK: begin
          if (phase_r == latc_pkg::PH_ARMED || phase_r == latc_pkg::PH_COUNTING) begin
            ram_we   = 1'b1;
            widx_nxt = widx_inc;
            prev_nxt = sample;
            if (fill_r != DEPTH_W) begin
              fill_nxt = fill_r + (AW+1)'(1);
            end
            if (phase_r == latc_pkg::PH_ARMED) begin
              if (trig_hit) begin
                fired     = 1'b1;
                atc_nxt   = '0;
                phase_nxt = latc_pkg::PH_COUNTING;
              end
            end else begin
              atc_nxt = atc_inc;
              if (atc_inc >= limit) begin
                phase_nxt = latc_pkg::PH_READOUT;
                rc_nxt    = '0;
              end
            end
          end
        end
        latc_pkg::OP_READ: begin
          if (phase_r == latc_pkg::PH_READOUT) begin
            ram_re   = 1'b1;
            rd_valid = 1'b1;
            if (rc_r == LAST_IDX) begin
              rd_last   = 1'b1;
              rc_nxt    = '0;
              atc_nxt   = '0;
              phase_nxt = latc_pkg::PH_ARMED;
            end else begin
              rc_nxt = rc_r + AW'(1);
            end
          end
        end
        latc_pkg::OP_ARM: begin
          phase_nxt = latc_pkg::PH_ARMED;
          atc_nxt   = '0;
          rc_nxt    = '0;
        end
        default: begin
          phase_nxt = latc_pkg::PH_IDLE;
          atc_nxt   = '0;
          rc_nxt    = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= latc_pkg::PH_IDLE;
      widx_r  <= '0;
      prev_r  <= '0;
      atc_r   <= '0;
      rc_r    <= '0;
      fill_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      widx_r  <= widx_nxt;
      prev_r  <= prev_nxt;
      atc_r   <= atc_nxt;
      rc_r    <= rc_nxt;
      fill_r  <= fill_nxt;
    end
  end

  assign ram_waddr = widx_r;
  assign ram_wdata = sample;
  assign ram_raddr = rd_addr;

  assign step.phase    = phase_nxt;
  assign step.rd_valid = rd_valid;
  assign step.rd_hit   = ({1'b0, rd_addr} < fill_r);
  assign step.last     = rd_last;
  assign step.fired    = fired;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_W)
    else $error("fill count beyond buffer depth");

  a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && op == latc_pkg::OP_READ && phase_r == latc_pkg::PH_READOUT &&
    rc_r == LAST_IDX |=> phase_r == latc_pkg::PH_ARMED && rc_r == '0)
    else $error("engine did not re-arm after the final readout");

  a_fire_counts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && fired |=> phase_r == latc_pkg::PH_COUNTING && atc_r == '0)
    else $error("trigger did not start the post-trigger count");
`endif

endmodule

// ===== hw/rtl/logic_analyzer_trigger_capture.sv =====
// Logic analyzer capture engine with a masked edge trigger.
// Input channel: in_tuser carries the operation (tick, read, arm, stop),
// in_tdata the sixteen pin levels used on a tick. One result transfer leaves
// on the output channel for every input transfer, in order.
// Result: out_tdata is the captured sample on a read, out_tuser holds the
// phase after the item, read valid and trigger flags, out_tlast marks the
// final sample of a readout run (oldest entry first).
// Configuration: cfg_we/cfg_addr/cfg_wdata write pin mask, edge level and
// post-trigger count; write only while no item is in flight.
// A result passes the middle stage and then the output register. Throughput:
// one item every cycle while the receiver takes results; the state update
// and the sample RAM access both happen on the input transfer edge, and the
// RAM's registered read port holds the data alongside the middle stage.
// Reset: phase idle, counters and indexes zero, registers to defaults.
// There is no clearing pass; a fill count makes entries never written read
// as zero, so items are taken from the first cycle after reset.
// A stalled receiver holds the output register; one more item may wait in
// the middle stage, after which in_tready drops until the output drains.
module logic_analyzer_trigger_capture #(
  parameter int BUFFER_DEPTH = latc_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [latc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [latc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // [15:0] sample_value
  input  logic [1:0]                      in_tuser,   // [1:0] operation
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [15:0]                     out_tdata,  // [15:0] read_data
  output logic [3:0]                      out_tuser,  // [1:0] phase, [2] read_valid,
                                                      // [3] triggered_now
  output logic                            out_tlast   // last_sample
);

  localparam int AW = $clog2(BUFFER_DEPTH);

  logic                          in_accept;
  logic                          advance;
  latc_pkg::step_t               step;
  latc_pkg::step_t               s1_r;
  logic                          s1_v_r, s1_v_nxt;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [latc_pkg::SAMPLE_W-1:0] ram_wdata;
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;
  logic [latc_pkg::SAMPLE_W-1:0] ram_rdata;

  logic                          out_v_r;
  logic [15:0]                   out_tdata_r;
  logic [3:0]                    out_tuser_r;
  logic                          out_tlast_r;

  assign advance   = !out_v_r || out_tready;
  assign in_tready = !s1_v_r || advance;
  assign in_accept = in_tvalid && in_tready;

  latc_core #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_accept (in_accept),
    .op        (in_tuser),
    .sample    (in_tdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .step      (step)
  );

  latc_ram #(
    .WIDTH(latc_pkg::SAMPLE_W),
    .DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (in_accept) begin
      s1_v_nxt = 1'b1;
    end else if (advance) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      if (advance) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  // payload: middle stage on transfer, output when it moves on
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= step;
    end
    if (advance && s1_v_r) begin
      out_tdata_r <= (s1_r.rd_valid && s1_r.rd_hit) ? ram_rdata : '0;
      out_tuser_r <= {s1_r.fired, s1_r.rd_valid, s1_r.phase};
      out_tlast_r <= s1_r.last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

`ifndef SYNTH
  a_ram_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !advance |=> $stable(ram_rdata))
    else $error("read data changed while the middle stage was held");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && advance |=> out_v_r)
    else $error("middle stage item lost on its way to the output");

  a_no_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tuser_r[2] |-> out_tdata_r == '0 && !out_tlast_r)
    else $error("data or last flag on a result without a read");
`endif

endmodule

// ===== test/tb.sv =====
module tb;
  import latc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MEM_DEPTH   = 1024;
  localparam int NUM_PHASES  = 5;

  typedef struct packed {
    logic [PHASE_W-1:0]  phase;
    logic [SAMPLE_W-1:0] rdata;
    logic                rvalid;
    logic                last;
    logic                fired;
  } capture_result_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [SAMPLE_W-1:0] sample;
  } capture_item_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [SAMPLE_W-1:0] sample;
    logic                typed;
    capture_result_t     want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0] in_tuser = OP_TICK;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [3:0] out_tuser;
  logic out_tlast;

  logic_analyzer_trigger_capture DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  // capture engine prediction state
  logic [SAMPLE_W-1:0] sample_mem [MEM_DEPTH];
  logic [CNT_W-1:0]    wr_index;
  logic [SAMPLE_W-1:0] prev_sample;
  logic [CNT_W-1:0]    post_ticks;
  logic [PHASE_W-1:0]  cap_phase;
  int unsigned         read_ptr;
  logic [SAMPLE_W-1:0] pin_mask;
  logic [SAMPLE_W-1:0] edge_level;
  logic [CNT_W-1:0]    post_count;

  capture_result_t expected_results[$];
  capture_item_t   pending_items[$];

  int cycle_count = 0;
  int mismatch_count = 0;
  int results_checked = 0;
  int items_sent = 0;
  int triggers_seen = 0;
  int readouts_done = 0;
  int samples_read = 0;
  int phase_items;
  int phase_budget;

  directed_row_t directed_rows [18] = '{
    '{OP_READ, 16'h0000, 1'b1, '{PH_IDLE,     16'h0000, 1'b0, 1'b0, 1'b0}},
    '{OP_TICK, 16'hFFFF, 1'b1, '{PH_IDLE,     16'h0000, 1'b0, 1'b0, 1'b0}},
    '{OP_STOP, 16'h0000, 1'b1, '{PH_IDLE,     16'h0000, 1'b0, 1'b0, 1'b0}},
    '{OP_ARM,  16'hFFFF, 1'b1, '{PH_ARMED,    16'h0000, 1'b0, 1'b0, 1'b0}},
    '{OP_ARM,  16'h0000, 1'b1, '{PH_ARMED,    16'h0000, 1'b0, 1'b0, 1'b0}},
    '{OP_TICK, 16'hFFFF, 1'b1, '{PH_ARMED,    16'h0000, 1'b0, 1'b0, 1'b0}},
    '{OP_TICK, 16'h0000, 1'b1, '{PH_COUNTING, 16'h0000, 1'b0, 1'b0, 1'b1}},
    '{OP_TICK, 16'h1234, 1'b1, '{PH_COUNTING, 16'h0000, 1'b0, 1'b0, 1'b0}},
    '{OP_READ, 16'hFFFF, 1'b1, '{PH_COUNTING, 16'h0000, 1'b0, 1'b0, 1'b0}},
    '{OP_ARM,  16'h0000, 1'b1, '{PH_ARMED,    16'h0000, 1'b0, 1'b0, 1'b0}},
    '{OP_TICK, 16'h1235, 1'b1, '{PH_ARMED,    16'h0000, 1'b0, 1'b0, 1'b0}},
    '{OP_TICK, 16'h1234, 1'b1, '{PH_COUNTING, 16'h0000, 1'b0, 1'b0, 1'b1}},
    '{OP_STOP, 16'hFFFF, 1'b1, '{PH_IDLE,     16'h0000, 1'b0, 1'b0, 1'b0}},
    '{OP_TICK, 16'h0000, 1'b1, '{PH_IDLE,     16'h0000, 1'b0, 1'b0, 1'b0}},
    '{OP_ARM,  16'h0000, 1'b1, '{PH_ARMED,    16'h0000, 1'b0, 1'b0, 1'b0}},
    // first tick after arming compares against the last stored sample
    '{OP_TICK, 16'hFFFE, 1'b0, '0},
    '{OP_TICK, 16'h0001, 1'b0, '0},
    '{OP_TICK, 16'hFFFE, 1'b0, '0}
  };

  function automatic void reset_capture_model();
    for (int i = 0; i < MEM_DEPTH; i++) sample_mem[i] = '0;
    wr_index = '0;
    prev_sample = '0;
    post_ticks = '0;
    cap_phase = PH_IDLE;
    read_ptr = 0;
    pin_mask = RST_PIN_MASK;
    edge_level = RST_EDGE_LEVEL;
    post_count = RST_POST_COUNT;
  endfunction

  function automatic capture_result_t predict_capture(logic [OP_W-1:0] op,
                                                     logic [SAMPLE_W-1:0] s);
    capture_result_t r;
    logic [SAMPLE_W-1:0] changed;
    logic [SAMPLE_W-1:0] level_ok;
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] addr;
    r = '0;
    case (op)
      OP_TICK: begin
        if (cap_phase == PH_ARMED || cap_phase == PH_COUNTING) begin
          if (cap_phase == PH_ARMED) begin
            changed = (s ^ prev_sample) & pin_mask;
            level_ok = ~(prev_sample ^ edge_level);
            if ((changed & level_ok) != '0) begin
              r.fired = 1'b1;
              post_ticks = '0;
              cap_phase = PH_COUNTING;
            end
          end else begin
            limit = (post_count == '0) ? 10'd1 : post_count;
            post_ticks = post_ticks + 10'd1;
            if (post_ticks >= limit) begin
              cap_phase = PH_READOUT;
              read_ptr = 0;
            end
          end
          sample_mem[wr_index] = s;
          wr_index = wr_index + 10'd1;
          prev_sample = s;
        end
      end
      OP_READ: begin
        if (cap_phase == PH_READOUT) begin
          // oldest entry sits at the write index
          addr = wr_index + read_ptr[CNT_W-1:0];
          r.rdata = sample_mem[addr];
          r.rvalid = 1'b1;
          read_ptr++;
          if (read_ptr >= MEM_DEPTH) begin
            r.last = 1'b1;
            read_ptr = 0;
            post_ticks = '0;
            cap_phase = PH_ARMED;
          end
        end
      end
      OP_ARM: begin
        cap_phase = PH_ARMED;
        post_ticks = '0;
        read_ptr = 0;
      end
      default: begin
        cap_phase = PH_IDLE;
        post_ticks = '0;
        read_ptr = 0;
      end
    endcase
    r.phase = cap_phase;
    return r;
  endfunction

  task automatic queue_item(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] s,
                            input bit use_typed = 1'b0, input capture_result_t typed = '0);
    capture_result_t r;
    capture_item_t it;
    r = predict_capture(op, s);
    expected_results.push_back(use_typed ? typed : r);
    it.op = op;
    it.sample = s;
    pending_items.push_back(it);
    phase_items++;
  endtask

  // one arm-trigger-readout run, or a few stray items
  task automatic queue_capture_run(input bit clean);
    int roll;
    int k;
    int abort_at;
    logic [SAMPLE_W-1:0] s;
    roll = clean ? 9 : $urandom_range(0, 9);
    if (roll < 2) begin
      repeat ($urandom_range(1, 6))
        queue_item(OP_W'($urandom_range(0, 3)), SAMPLE_W'($urandom));
      return;
    end
    queue_item(OP_ARM, SAMPLE_W'($urandom));
    k = 0;
    while (cap_phase == PH_ARMED && k < 60) begin
      if ($urandom_range(0, 1)) s = SAMPLE_W'($urandom);
      else s = prev_sample ^ (SAMPLE_W'($urandom) & ~pin_mask);
      queue_item(OP_TICK, s);
      k++;
    end
    if (cap_phase == PH_ARMED) begin
      queue_item(OP_STOP, SAMPLE_W'($urandom));
      return;
    end
    while (cap_phase == PH_COUNTING) begin
      if (roll == 3 && $urandom_range(0, 19) == 0) begin
        queue_item($urandom_range(0, 1) ? OP_ARM : OP_STOP, SAMPLE_W'($urandom));
        return;
      end
      if ($urandom_range(0, 49) == 0) queue_item(OP_READ, SAMPLE_W'($urandom));
      else queue_item(OP_TICK, SAMPLE_W'($urandom));
    end
    abort_at = (roll == 2) ? $urandom_range(0, MEM_DEPTH - 1) : 2 * MEM_DEPTH;
    k = 0;
    while (cap_phase == PH_READOUT) begin
      if (k == abort_at || phase_items >= phase_budget)
        queue_item($urandom_range(0, 1) ? OP_ARM : OP_STOP, SAMPLE_W'($urandom));
      else if ($urandom_range(0, 29) == 0)
        queue_item(OP_TICK, SAMPLE_W'($urandom));
      else begin
        queue_item(OP_READ, SAMPLE_W'($urandom));
        k++;
      end
    end
  endtask

  task automatic send_pending();
    int burst;
    int gap;
    bit hold;
    capture_item_t it;
    while (pending_items.size() > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && pending_items.size() > 0) begin
        it = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= it.sample;
        in_tuser  <= it.op;
        @(posedge clk);
        while (!in_tready) @(posedge clk);
        burst--;
        items_sent++;
      end
      hold = ($urandom_range(0, 29) == 0);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (hold && gap == 0) gap = 1;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        // let everything already sent come back before going on
        if (hold) while (expected_results.size() > pending_items.size()) @(posedge clk);
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;
  endtask

  task automatic drain_results();
    while (expected_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capture_reg(input logic [CFG_ADDR_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_PIN_MASK:   pin_mask = val;
      CFG_EDGE_LEVEL: edge_level = val;
      CFG_POST_COUNT: post_count = val[CNT_W-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // receiver stall pattern changes with bits 9:8 of the cycle count
  always @(posedge clk) begin
    case (cycle_count[9:8])
      2'd0:    out_tready <= 1'b1;
      2'd1:    out_tready <= ($urandom_range(0, 9) < 7);
      2'd2:    out_tready <= (cycle_count % 5) != 0;
      default: out_tready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  always @(posedge clk) begin : check_results
    capture_result_t want;
    capture_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.phase  = out_tuser[1:0];
      got.rvalid = out_tuser[2];
      got.fired  = out_tuser[3];
      got.rdata  = out_tdata;
      got.last   = out_tlast;
      if (got.fired) triggers_seen++;
      if (got.rvalid) samples_read++;
      if (got.last) readouts_done++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result transfer: phase %0d data %h valid %b last %b trig %b",
                   got.phase, got.rdata, got.rvalid, got.last, got.fired);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (got.phase !== want.phase || got.rdata !== want.rdata ||
            got.rvalid !== want.rvalid || got.last !== want.last ||
            got.fired !== want.fired) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"result %0d: expected phase %0d data %h valid %b last %b trig %b, ",
                      "got phase %0d data %h valid %b last %b trig %b"},
                     results_checked, want.phase, want.rdata, want.rvalid, want.last,
                     want.fired, got.phase, got.rdata, got.rvalid, got.last, got.fired);
        end
      end
    end
  end

  initial begin
    reset_capture_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    phase_items = 0;
    phase_budget = 0;
    foreach (directed_rows[i])
      queue_item(directed_rows[i].op, directed_rows[i].sample,
                 directed_rows[i].typed, directed_rows[i].want);
    send_pending();
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: phase_budget = 350;   // registers left at their reset values
        1: begin
          write_capture_reg(CFG_PIN_MASK, 16'hFFFF);
          write_capture_reg(CFG_EDGE_LEVEL, 16'h0000);
          write_capture_reg(CFG_POST_COUNT, 16'd1);
          phase_budget = 1100;
        end
        2: begin
          write_capture_reg(CFG_PIN_MASK, CFG_DATA_W'($urandom));
          write_capture_reg(CFG_EDGE_LEVEL, CFG_DATA_W'($urandom));
          write_capture_reg(CFG_POST_COUNT, CFG_DATA_W'($urandom_range(2, 40)));
          phase_budget = 250;
        end
        3: begin
          // a post-trigger count of zero behaves as one
          write_capture_reg(CFG_PIN_MASK, 16'h8000);
          write_capture_reg(CFG_EDGE_LEVEL, 16'hFFFF);
          write_capture_reg(CFG_POST_COUNT, 16'd0);
          phase_budget = 150;
        end
        default: begin
          write_capture_reg(CFG_PIN_MASK, 16'h0000);
          write_capture_reg(CFG_EDGE_LEVEL, CFG_DATA_W'($urandom));
          write_capture_reg(CFG_POST_COUNT, CFG_DATA_W'($urandom_range(1, 1023)));
          phase_budget = 60;
        end
      endcase
      phase_items = 0;
      queue_capture_run(1'b1);
      while (phase_items < phase_budget) queue_capture_run(1'b0);
      send_pending();
      drain_results();
    end

    repeat (6) @(posedge clk);
    $display("sent %0d items over %0d register settings, checked %0d results",
             items_sent, NUM_PHASES, results_checked);
    $display("saw %0d triggers, %0d samples read back, %0d complete readouts",
             triggers_seen, samples_read, readouts_done);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count,
               expected_results.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
